// ===== rtl/core/ncc_pkg.sv =====
// Shared types and constants of the nearest-centroid classifier.
package ncc_pkg;

	localparam int unsigned NUM_DESC  = 9;	// descriptors per vector / centroid row
	localparam int unsigned ROW_W     = 6;	// width of the row_index field
	localparam int unsigned RES_IDX_W = 6;	// width of the cluster_index field
	localparam int unsigned SC_W      = 8;	// width of the stored_cluster field
	localparam int unsigned COUNT_W   = 7;	// width of the cluster_count register
	localparam int unsigned PADDR_W   = 3;
	localparam int unsigned PDATA_W   = 32;

	// register addresses
	localparam logic [PADDR_W-1:0] ADDR_CLUSTER_COUNT = 3'd0;

	// action codes
	localparam logic ACT_QUERY = 1'b0;
	localparam logic ACT_LOAD  = 1'b1;

	// search sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	// tag that travels with each row through the distance pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

// ===== rtl/core/nearest_centroid_classifier.sv =====
// Nearest-centroid classifier over nine signed fixed-point descriptors. A load transfer
// (action = 1) writes its nine descriptors as centroid row row_index (modulo
// MAX_CLUSTERS) and gives no result; it does not hold the input busy. A query
// transfer (action = 0) gives exactly one result. With cluster_count at zero the result
// is no_clusters = 1, cluster_index = 0; with stored_cluster in 0 .. count-1 that index
// comes back as is; both pass a holding register and then the output register once
// that register is free. The input is not ready while the holding register is full,
// so no new item is taken until that result has moved on to the output register.
// Otherwise the rows 0 .. count-1 are read from the centroid memory one row per cycle,
// each passing through nine parallel |q-r| units, nine squarers and a saturating sum,
// and the row with the least squared distance wins (lowest index on a tie). Such a query
// has its result pass the memory read register, three distance stages, the holding
// register and the output register; the input is ready again once the result has left
// the holding register. The single read port of the centroid memory bounds the scan.
// cluster_count above MAX_CLUSTERS counts as MAX_CLUSTERS. Rows are expected to be
// loaded before a query compares against them; the store has no reset and no valid bits.
// The user must write cluster_count over the APB port at byte address 0 only while the
// block is idle; the block itself does not enforce this. The output register lets one
// finished result wait while the next item is taken.
module nearest_centroid_classifier #(
	parameter int unsigned MAX_CLUSTERS     = 64,
	parameter int unsigned DESCRIPTOR_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ncc_pkg::PADDR_W-1:0]        paddr,
	input  logic [ncc_pkg::PDATA_W-1:0]        pwdata,
	output logic [ncc_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	input  logic [ncc_pkg::ROW_W-1:0]          row_index,
	input  logic signed [ncc_pkg::SC_W-1:0]    stored_cluster,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] brightness,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] motion_amount,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] stereo_width,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] noisiness,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] bass_weight,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] density_value,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] evolution,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] roughness,
	input  logic signed [DESCRIPTOR_WIDTH-1:0] wetness,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ncc_pkg::RES_IDX_W-1:0]      cluster_index,
	output logic                               no_clusters
);

	localparam int unsigned DW     = DESCRIPTOR_WIDTH;
	localparam int unsigned IDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_CLUSTERS + 1);
	localparam int unsigned CMP_W  = CNT_W + ncc_pkg::SC_W;
	localparam int unsigned ROW_N  = 2 ** ncc_pkg::ROW_W;
	localparam int unsigned SUM_W  = 2 * DW + 4;
	localparam int unsigned DIST_W = (SUM_W > 64) ? 64 : SUM_W;
	localparam int unsigned ROW_BITS = ncc_pkg::NUM_DESC * DW;

	// ---------------------------------------------------------------- config
	logic [ncc_pkg::COUNT_W-1:0] cluster_count_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= '0;
		end else if (cfg_wr && paddr == ncc_pkg::ADDR_CLUSTER_COUNT) begin
			cluster_count_q <= pwdata[ncc_pkg::COUNT_W-1:0];
		end
	end

	assign prdata = (paddr == ncc_pkg::ADDR_CLUSTER_COUNT) ?
		ncc_pkg::PDATA_W'(cluster_count_q) : '0;

	// count in use, clamped to capacity
	logic [CNT_W-1:0] count_eff;

	always_comb begin
		if (32'(cluster_count_q) > 32'(MAX_CLUSTERS)) begin
			count_eff = CNT_W'(MAX_CLUSTERS);
		end else begin
			count_eff = CNT_W'(cluster_count_q);
		end
	end

	// ---------------------------------------------------------------- input decode
	logic in_xfer;
	logic is_load;
	logic no_cl;
	logic sc_hit;
	logic start_search;

	logic [ncc_pkg::NUM_DESC-1:0][DW-1:0] desc_in;

	assign desc_in = {wetness, roughness, evolution, density_value, bass_weight,
		noisiness, stereo_width, motion_amount, brightness};

	assign in_xfer      = in_valid & in_ready;
	assign is_load      = (action == ncc_pkg::ACT_LOAD);
	assign no_cl        = (count_eff == '0);
	assign sc_hit       = !stored_cluster[ncc_pkg::SC_W-1] &&
		(CMP_W'(stored_cluster[ncc_pkg::SC_W-2:0]) < CMP_W'(count_eff));
	assign start_search = in_xfer && !is_load && !no_cl && !sc_hit;

	// row_index wraps modulo capacity: constant lookup
	logic [IDX_W-1:0] wrap_row [ROW_N];

	for (genvar g = 0; g < ROW_N; g++) begin : g_wrap
		localparam int unsigned WRAPPED = g % MAX_CLUSTERS;
		assign wrap_row[g] = IDX_W'(WRAPPED);
	end

	// ---------------------------------------------------------------- sequencer
	ncc_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0] rd_cnt_q;
	logic [CNT_W-1:0] count_q;
	logic             rd_en;
	logic             last_issue;
	logic             pend_q;
	logic             scan_done;

	ncc_pkg::tag_t    tag_s1, tag_s4;
	logic [IDX_W-1:0] idx_s1, idx_s4;
	logic [DIST_W-1:0] dist_s4;

	assign last_issue = (rd_cnt_q + CNT_W'(1)) == count_q;
	assign scan_done  = tag_s4.valid && tag_s4.last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ncc_pkg::ST_IDLE: begin
				if (start_search) begin
					state_d = ncc_pkg::ST_ISSUE;
				end
			end
			ncc_pkg::ST_ISSUE: begin
				if (last_issue) begin
					state_d = ncc_pkg::ST_DRAIN;
				end
			end
			ncc_pkg::ST_DRAIN: begin
				if (scan_done) begin
					state_d = ncc_pkg::ST_IDLE;
				end
			end
			default: state_d = ncc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			ncc_pkg::ST_IDLE:  in_ready = !pend_q;
			ncc_pkg::ST_ISSUE: rd_en    = 1'b1;
			ncc_pkg::ST_DRAIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ncc_pkg::ST_IDLE;
			rd_cnt_q <= '0;
			tag_s1   <= '0;
		end else begin
			state_q <= state_d;
			if (start_search) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			tag_s1.valid <= rd_en;
			tag_s1.last  <= rd_en & last_issue;
		end
	end

	// query held for the whole scan
	logic [ncc_pkg::NUM_DESC-1:0][DW-1:0] query_q;

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			query_q <= desc_in;
			count_q <= count_eff;
		end
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
	end

	// ---------------------------------------------------------------- datapath
	logic [ncc_pkg::NUM_DESC-1:0][DW-1:0] row_s1;

	ncc_centroid_mem #(
		.DEPTH  (MAX_CLUSTERS),
		.ADDR_W (IDX_W),
		.DATA_W (ROW_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (in_xfer & is_load),
		.wr_addr (wrap_row[row_index]),
		.wr_data (desc_in),
		.rd_en   (rd_en),
		.rd_addr (rd_cnt_q[IDX_W-1:0]),
		.rd_data (row_s1)
	);

	ncc_distance #(
		.DESC_W (DW),
		.IDX_W  (IDX_W),
		.DIST_W (DIST_W)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (query_q),
		.row_s1  (row_s1),
		.tag_s1  (tag_s1),
		.idx_s1  (idx_s1),
		.tag_s4  (tag_s4),
		.idx_s4  (idx_s4),
		.dist_s4 (dist_s4)
	);

	// running minimum; strict less keeps the lowest index on a tie
	logic              first_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              take;
	logic [IDX_W-1:0]  win_idx;

	assign take    = tag_s4.valid && (first_q || dist_s4 < best_dist_q);
	assign win_idx = take ? idx_s4 : best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (start_search) begin
			first_q <= 1'b1;
		end else if (tag_s4.valid) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_dist_q <= dist_s4;
			best_idx_q  <= idx_s4;
		end
	end

	// ---------------------------------------------------------------- result
	logic                          res_set;
	logic [ncc_pkg::RES_IDX_W-1:0] res_idx_d;
	logic                          res_nocl_d;
	logic [ncc_pkg::RES_IDX_W-1:0] pend_idx_q;
	logic                          pend_nocl_q;
	logic                          out_free;
	logic                          out_valid_q;
	logic [ncc_pkg::RES_IDX_W-1:0] out_idx_q;
	logic                          out_nocl_q;

	assign res_set = (in_xfer && !is_load && (no_cl || sc_hit)) || scan_done;

	always_comb begin
		if (scan_done) begin
			res_idx_d  = ncc_pkg::RES_IDX_W'(win_idx);
			res_nocl_d = 1'b0;
		end else if (no_cl) begin
			res_idx_d  = '0;
			res_nocl_d = 1'b1;
		end else begin
			res_idx_d  = stored_cluster[ncc_pkg::RES_IDX_W-1:0];
			res_nocl_d = 1'b0;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_set) begin
				pend_q <= 1'b1;
			end else if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end
			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			pend_idx_q  <= res_idx_d;
			pend_nocl_q <= res_nocl_d;
		end
		if (pend_q && out_free) begin
			out_idx_q  <= pend_idx_q;
			out_nocl_q <= pend_nocl_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign cluster_index = out_idx_q;
	assign no_clusters   = out_nocl_q;

endmodule

// ===== rtl/core/ncc_centroid_mem.sv =====
// Centroid row store: one write port, one read port, registered read data.
module ncc_centroid_mem #(
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = 6,
	parameter int unsigned DATA_W = 144
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/ncc_distance.sv =====
// Squared Euclidean distance pipeline: difference, square, saturating sum.
module ncc_distance #(
	parameter int unsigned DESC_W = 16,
	parameter int unsigned IDX_W  = 6,
	parameter int unsigned DIST_W = 36
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [ncc_pkg::NUM_DESC-1:0][DESC_W-1:0]   query,
	input  logic [ncc_pkg::NUM_DESC-1:0][DESC_W-1:0]   row_s1,
	input  ncc_pkg::tag_t                              tag_s1,
	input  logic [IDX_W-1:0]                           idx_s1,
	output ncc_pkg::tag_t                              tag_s4,
	output logic [IDX_W-1:0]                           idx_s4,
	output logic [DIST_W-1:0]                          dist_s4
);

	localparam int unsigned SQ_W  = 2 * DESC_W;
	localparam int unsigned SUM_W = SQ_W + 4;
	localparam logic [SUM_W-1:0] SAT_LIM = SUM_W'(64'hFFFF_FFFF_FFFF_FFFF);

	logic [DESC_W:0]   diff_c [ncc_pkg::NUM_DESC];
	logic [DESC_W:0]   neg_c  [ncc_pkg::NUM_DESC];
	logic [DESC_W-1:0] mag_s2 [ncc_pkg::NUM_DESC];
	logic [SQ_W-1:0]   sq_s3  [ncc_pkg::NUM_DESC];
	logic [SUM_W-1:0]  sum_c;
	logic [SUM_W-1:0]  sat_c;

	ncc_pkg::tag_t     tag_s2, tag_s3, tag_s4_q;
	logic [IDX_W-1:0]  idx_s2, idx_s3, idx_s4_q;
	logic [DIST_W-1:0] dist_s4_q;

	// |q - r|, exact in DESC_W+1 bits; magnitude fits DESC_W bits
	always_comb begin
		for (int k = 0; k < ncc_pkg::NUM_DESC; k++) begin
			diff_c[k] = {query[k][DESC_W-1], query[k]} - {row_s1[k][DESC_W-1], row_s1[k]};
			neg_c[k]  = ~diff_c[k] + (DESC_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ncc_pkg::NUM_DESC; k++) begin
			mag_s2[k] <= diff_c[k][DESC_W] ? neg_c[k][DESC_W-1:0] : diff_c[k][DESC_W-1:0];
			sq_s3[k]  <= mag_s2[k] * mag_s2[k];
		end
		idx_s2    <= idx_s1;
		idx_s3    <= idx_s2;
		idx_s4_q  <= idx_s3;
		dist_s4_q <= DIST_W'(sat_c);
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < ncc_pkg::NUM_DESC; k++) begin
			sum_c = sum_c + SUM_W'(sq_s3[k]);
		end
		sat_c = (sum_c > SAT_LIM) ? SAT_LIM : sum_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3   <= '0;
			tag_s4_q <= '0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			tag_s4_q <= tag_s3;
		end
	end

	assign tag_s4  = tag_s4_q;
	assign idx_s4  = idx_s4_q;
	assign dist_s4 = dist_s4_q;

endmodule

// ===== dv/centroid_match_checker.sv =====
// Checker for the nearest-centroid classifier: predicts and compares each result.
`timescale 1ns / 100ps

module centroid_match_checker #(
	parameter int unsigned MAX_CLUSTERS     = 64,
	parameter int unsigned DESCRIPTOR_WIDTH = 16
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    psel,
	input  logic                                                    penable,
	input  logic                                                    pwrite,
	input  logic [ncc_pkg::PADDR_W-1:0]                             paddr,
	input  logic [ncc_pkg::PDATA_W-1:0]                             pwdata,
	input  logic [ncc_pkg::PDATA_W-1:0]                             prdata,
	input  logic                                                    pready,
	input  logic                                                    in_valid,
	input  logic                                                    in_ready,
	input  logic                                                    action,
	input  logic [ncc_pkg::ROW_W-1:0]                               row_index,
	input  logic [ncc_pkg::SC_W-1:0]                                stored_cluster,
	input  logic [ncc_pkg::NUM_DESC-1:0][DESCRIPTOR_WIDTH-1:0]      desc,
	input  logic                                                    out_valid,
	input  logic                                                    out_ready,
	input  logic [ncc_pkg::RES_IDX_W-1:0]                           cluster_index,
	input  logic                                                    no_clusters,
	output int                                                      errors,
	output int                                                      labels_due
);

	typedef logic [ncc_pkg::NUM_DESC-1:0][DESCRIPTOR_WIDTH-1:0] desc_vec_t;
	typedef longint unsigned dist_t;

	typedef struct packed {
		logic [ncc_pkg::RES_IDX_W-1:0] idx;
		logic                          none;
	} label_t;

	label_t                              awaited_labels [$];
	logic signed [DESCRIPTOR_WIDTH-1:0]  centroids [MAX_CLUSTERS][ncc_pkg::NUM_DESC];
	logic [ncc_pkg::COUNT_W-1:0]         count_reg;

	// exact squared distance; nine 17-bit differences cannot overflow 64 bits
	function automatic dist_t sq_distance(int row, desc_vec_t q);
		longint e;
		dist_t  acc;
		acc = 0;
		for (int k = 0; k < ncc_pkg::NUM_DESC; k++) begin
			e = longint'($signed(q[k])) - longint'(centroids[row][k]);
			acc = acc + dist_t'(e * e);
		end
		return acc;
	endfunction

	function automatic label_t nearest_label(logic [ncc_pkg::SC_W-1:0] sc, desc_vec_t q);
		int     eff;
		int     sc_val;
		int     best;
		dist_t  best_d;
		dist_t  d;
		label_t r;
		eff = (count_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(count_reg);
		sc_val = int'($signed(sc));
		r.none = 1'b0;
		if (eff == 0) begin
			r.idx  = '0;
			r.none = 1'b1;
		end else if (sc_val >= 0 && sc_val < eff) begin
			r.idx = sc[ncc_pkg::RES_IDX_W-1:0];
		end else begin
			best = 0;
			best_d = sq_distance(0, q);
			for (int c = 1; c < eff; c++) begin
				d = sq_distance(c, q);
				// strict compare: lowest index keeps a tie
				if (d < best_d) begin
					best_d = d;
					best = c;
				end
			end
			r.idx = ncc_pkg::RES_IDX_W'(best);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		label_t exp_label;
		int     fails;
		if (!arst_n) begin
			awaited_labels.delete();
			count_reg = '0;
			errors <= 0;
			labels_due <= 0;
		end else begin
			fails = 0;
			if (psel && penable && pready) begin
				if (pwrite && paddr == ncc_pkg::ADDR_CLUSTER_COUNT) begin
					count_reg = pwdata[ncc_pkg::COUNT_W-1:0];
				end else if (!pwrite && paddr == ncc_pkg::ADDR_CLUSTER_COUNT &&
						prdata !== ncc_pkg::PDATA_W'(count_reg)) begin
					$error("prdata: expected %0d, got %0d", count_reg, prdata);
					fails++;
				end
			end
			if (out_valid && out_ready) begin
				if (awaited_labels.size() == 0) begin
					$error("unexpected result: cluster_index %0d, no_clusters %0d",
						cluster_index, no_clusters);
					fails++;
				end else begin
					exp_label = awaited_labels.pop_front();
					if (cluster_index !== exp_label.idx) begin
						$error("cluster_index: expected %0d, got %0d",
							exp_label.idx, cluster_index);
						fails++;
					end
					if (no_clusters !== exp_label.none) begin
						$error("no_clusters: expected %0d, got %0d",
							exp_label.none, no_clusters);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action == ncc_pkg::ACT_LOAD) begin
					for (int k = 0; k < ncc_pkg::NUM_DESC; k++)
						centroids[row_index % MAX_CLUSTERS][k] = desc[k];
				end else begin
					awaited_labels.push_back(nearest_label(stored_cluster, desc));
				end
			end
			labels_due <= awaited_labels.size();
			errors <= errors + fails;
		end
	end

endmodule

// ===== dv/tb_nearest_centroid_classifier.sv =====
// Testbench top for the nearest-centroid classifier: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_nearest_centroid_classifier;

	localparam int unsigned MAX_CLUSTERS  = 64;
	localparam int unsigned DESC_W        = 16;
	// cycles with no transfer before the run is declared hung; covers the slowest
	// query plus sender gaps, receiver stalls and settle waits
	localparam int unsigned STALL_LIMIT   = 4000;
	// long enough for a query over 64 rows or a load to finish
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned PHASE_ITEMS   = 135;
	// beyond the register list; writes here must be dropped
	localparam logic [ncc_pkg::PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

	typedef logic [ncc_pkg::NUM_DESC-1:0][DESC_W-1:0] desc_vec_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [ncc_pkg::PADDR_W-1:0]     paddr = '0;
	logic [ncc_pkg::PDATA_W-1:0]     pwdata = '0;
	logic [ncc_pkg::PDATA_W-1:0]     prdata;
	logic                            pready;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            action = ncc_pkg::ACT_QUERY;
	logic [ncc_pkg::ROW_W-1:0]       row_index = '0;
	logic [ncc_pkg::SC_W-1:0]        stored_cluster = '0;
	desc_vec_t                       desc = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [ncc_pkg::RES_IDX_W-1:0]   cluster_index;
	logic                            no_clusters;

	int                              errors;
	int                              labels_due;
	int                              send_idle_pct = 0;
	int                              recv_stall_pct = 0;
	int                              quiet_cycles = 0;

	// what was last loaded into each row; used to aim queries near centroids and to copy rows
	desc_vec_t                       shadow [MAX_CLUSTERS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	nearest_centroid_classifier #(
		.MAX_CLUSTERS     (MAX_CLUSTERS),
		.DESCRIPTOR_WIDTH (DESC_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.row_index      (row_index),
		.stored_cluster (stored_cluster),
		.brightness     (desc[0]),
		.motion_amount  (desc[1]),
		.stereo_width   (desc[2]),
		.noisiness      (desc[3]),
		.bass_weight    (desc[4]),
		.density_value  (desc[5]),
		.evolution      (desc[6]),
		.roughness      (desc[7]),
		.wetness        (desc[8]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cluster_index  (cluster_index),
		.no_clusters    (no_clusters)
	);

	centroid_match_checker #(
		.MAX_CLUSTERS     (MAX_CLUSTERS),
		.DESCRIPTOR_WIDTH (DESC_W)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.row_index      (row_index),
		.stored_cluster (stored_cluster),
		.desc           (desc),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cluster_index  (cluster_index),
		.no_clusters    (no_clusters),
		.errors         (errors),
		.labels_due     (labels_due)
	);

	// receiver: stalls at the rate set for the current phase
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: any transfer on either channel resets the quiet counter
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[nearest_centroid_classifier] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One input transfer. Called at a rising edge; returns at the edge where the
	// item was taken with valid still high, so back-to-back items keep valid up.
	task automatic send(input logic act, input logic [ncc_pkg::ROW_W-1:0] row,
			input logic [ncc_pkg::SC_W-1:0] sc, input desc_vec_t d);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid       <= 1'b1;
		action         <= act;
		row_index      <= row;
		stored_cluster <= sc;
		desc           <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (act == ncc_pkg::ACT_LOAD)
			shadow[row] = d;
	endtask

	// Sender holds off until every outstanding result has come back.
	// At least one edge passes so valid is never dropped and raised in one step.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (labels_due != 0);
	endtask

	// APB write then read-back of cluster_count, only with the block idle.
	// Upper pwdata bits are random: the register keeps only its low seven.
	task automatic write_register(input logic [ncc_pkg::PADDR_W-1:0] addr,
			input logic [ncc_pkg::COUNT_W-1:0] value);
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {(ncc_pkg::PDATA_W-ncc_pkg::COUNT_W)'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// write lands at this edge; go straight into a read setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ncc_pkg::ADDR_CLUSTER_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// style 0: full random, 1: coarse grid (more ties), 2: corner values
	function automatic desc_vec_t random_vec(int style);
		desc_vec_t d;
		for (int k = 0; k < ncc_pkg::NUM_DESC; k++) begin
			case (style)
				0: d[k] = DESC_W'($urandom());
				1: d[k] = DESC_W'($urandom_range(7) << 13);
				default: begin
					case ($urandom_range(3))
						0: d[k] = 16'h7fff;
						1: d[k] = 16'h8000;
						2: d[k] = 16'h0000;
						default: d[k] = 16'hffff;
					endcase
				end
			endcase
		end
		return d;
	endfunction

	// One random item for a phase whose effective row count is eff.
	// All rows are loaded before this is used, so any search is legal.
	task automatic random_item(int eff);
		desc_vec_t                 d;
		desc_vec_t                 base;
		logic [ncc_pkg::SC_W-1:0]  sc;
		int                        pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			// loads; some duplicate an existing row to set up distance ties
			if ($urandom_range(99) < 15)
				d = shadow[$urandom_range(MAX_CLUSTERS-1)];
			else
				d = random_vec($urandom_range(2));
			send(ncc_pkg::ACT_LOAD, ncc_pkg::ROW_W'($urandom()),
				ncc_pkg::SC_W'($urandom()), d);
		end else begin
			// stored cluster: inside the count, anywhere, or the usual -1
			pick = $urandom_range(99);
			if (pick < 35 && eff > 0)
				sc = ncc_pkg::SC_W'($urandom_range(eff-1));
			else if (pick < 70)
				sc = ncc_pkg::SC_W'($urandom());
			else
				sc = '1;
			// descriptors: near a live centroid, on the grid, or random
			pick = $urandom_range(99);
			if (pick < 35) begin
				base = shadow[$urandom_range((eff > 0) ? eff-1 : 0)];
				for (int k = 0; k < ncc_pkg::NUM_DESC; k++)
					d[k] = base[k] + DESC_W'($urandom_range(32)) - DESC_W'(16);
			end else if (pick < 70) begin
				d = random_vec(1);
			end else begin
				d = random_vec($urandom_range(1) * 2);
			end
			send(ncc_pkg::ACT_QUERY, ncc_pkg::ROW_W'($urandom()), sc, d);
		end
	endtask

	initial begin
		int unsigned phase_count [11];
		int          eff;
		phase_count = '{64, 127, 1, 0, 65, 12, 37, 3, 100, 64, 2};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// reset count is zero: even a stored cluster of 0 must come back flagged
		send(ncc_pkg::ACT_QUERY, '0, 8'h00, '0);
		// corner rows; row 3 repeats row 0 so a query at full scale ties
		send(ncc_pkg::ACT_LOAD, 6'd0, 8'h00, {ncc_pkg::NUM_DESC{16'h7fff}});
		send(ncc_pkg::ACT_LOAD, 6'd1, 8'h00, {ncc_pkg::NUM_DESC{16'h8000}});
		send(ncc_pkg::ACT_LOAD, 6'd2, 8'h00, {ncc_pkg::NUM_DESC{16'h0000}});
		send(ncc_pkg::ACT_LOAD, 6'd3, 8'h00, {ncc_pkg::NUM_DESC{16'h7fff}});
		send(ncc_pkg::ACT_LOAD, 6'd63, 8'h00, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
		// write past the register list is dropped; count stays zero
		write_register(ADDR_UNMAPPED, 7'd5);
		send(ncc_pkg::ACT_QUERY, '0, 8'h02, {ncc_pkg::NUM_DESC{16'h7fff}});
		write_register(ncc_pkg::ADDR_CLUSTER_COUNT, 7'd0);
		send(ncc_pkg::ACT_QUERY, '0, 8'h7f, '0);
		write_register(ncc_pkg::ADDR_CLUSTER_COUNT, 7'd4);
		// ties between rows 0 and 3: lower index wins
		send(ncc_pkg::ACT_QUERY, '0, 8'hff, {ncc_pkg::NUM_DESC{16'h7fff}});
		// stored cluster at the signed extremes counts as absent
		send(ncc_pkg::ACT_QUERY, '0, 8'h80, {ncc_pkg::NUM_DESC{16'h8000}});
		send(ncc_pkg::ACT_QUERY, 6'd63, 8'h7f, '0);
		// stored cluster at count-1 is used, at count it is not
		send(ncc_pkg::ACT_QUERY, '0, 8'h03, {ncc_pkg::NUM_DESC{16'h8000}});
		send(ncc_pkg::ACT_QUERY, '0, 8'h04, {ncc_pkg::NUM_DESC{16'h8000}});
		send(ncc_pkg::ACT_QUERY, '0, 8'h00, {ncc_pkg::NUM_DESC{16'h8000}});
		// halfway between rows 1 and 2
		send(ncc_pkg::ACT_QUERY, '0, 8'hff, {ncc_pkg::NUM_DESC{16'hc000}});
		send(ncc_pkg::ACT_QUERY, 6'd63, 8'hff, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});

		// ---- fill every row so later searches never touch an unloaded one ----
		for (int r = 0; r < MAX_CLUSTERS; r++)
			send(ncc_pkg::ACT_LOAD, ncc_pkg::ROW_W'(r), ncc_pkg::SC_W'($urandom()),
				random_vec($urandom_range(2)));

		// ---- random phases: count setting and idle pattern change each phase ----
		for (int p = 0; p < 11; p++) begin
			write_register(ncc_pkg::ADDR_CLUSTER_COUNT, ncc_pkg::COUNT_W'(phase_count[p]));
			eff = (phase_count[p] > MAX_CLUSTERS) ? MAX_CLUSTERS : phase_count[p];
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  = 78;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 78;
				end
				default: begin
					send_idle_pct  = 21;
					recv_stall_pct <= 21;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mid-phase drain in some phases: pipeline empties completely
				if (i == PHASE_ITEMS / 2 && p % 3 == 0)
					pause_until_drained();
				random_item(eff);
			end
		end

		// ---- wind down: all results in, then let any load settle ----
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && labels_due == 0)
			$display("[nearest_centroid_classifier] OK");
		else
			$display("[nearest_centroid_classifier] ERROR");
		$finish;
	end

endmodule
